@@ rtl/core/cbwu_pkg.sv @@
// Shared types, constants and helpers of the clipmap block window update.
package cbwu_pkg;

    localparam int MAX_LEVELS_DEF = 8;
    localparam int SLOTS          = 36;
    localparam int WIN            = 6;
    localparam int SLOT_W         = 6;
    localparam int LV_W           = 4;   // covers up to sixteen levels

    // configuration register indexes
    localparam logic REG_BLOCK_SIZE   = 1'b0;
    localparam logic REG_TERRAIN_SIZE = 1'b1;

    // one classified item, front to back
    typedef struct packed {
        logic            action;
        logic [LV_W-1:0] lv;
        logic [15:0]     gx;
        logic [15:0]     gy;
        logic [15:0]     sx;
        logic [15:0]     sy;
        logic            px;         // grid parity, inner region starts at px + 1
        logic            py;
        logic [15:0]     lo;
        logic [16:0]     hi;
        logic [2:0]      min_level;
    } t_job;

    typedef struct packed {
        logic [15:0] bx;
        logic [15:0] by;
        logic [2:0]  lx;
        logic [2:0]  ly;
        logic        inner;
    } t_slot;

    function automatic logic inner_at(input logic [2:0] c, input logic [2:0] r,
                                      input logic px, input logic py);
        logic [2:0] ix;
        logic [2:0] iy;
        ix = {2'b00, px} + 3'd1;
        iy = {2'b00, py} + 3'd1;
        return (c >= ix) && (c < ix + 3'd3) && (r >= iy) && (r < iy + 3'd3);
    endfunction

    // window entry j (row major) of the window starting at sx, sy
    function automatic t_slot win_entry(input logic [SLOT_W-1:0] j, input logic [15:0] sx,
                                        input logic [15:0] sy, input logic px,
                                        input logic py);
        t_slot      e;
        logic [11:0] prod;
        logic [2:0] r;
        logic [2:0] c;
        prod    = 12'(j) * 12'd43;          // j / 6 for j below 48
        r       = prod[10:8];
        c       = 3'(j - SLOT_W'(r) * SLOT_W'(WIN));
        e.bx    = sx + 16'(c);
        e.by    = sy + 16'(r);
        e.lx    = c;
        e.ly    = r;
        e.inner = inner_at(c, r, px, py);
        return e;
    endfunction

endpackage

@@ rtl/core/cbwu_if.sv @@
// Item and result channel interfaces.
interface cbwu_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [2:0]  level;
    logic [15:0] cam_x;
    logic [15:0] cam_z;
    logic signed [15:0] height_above_ground;

    modport source (output valid, action, level, cam_x, cam_z, height_above_ground,
                    input ready);
    modport sink   (input valid, action, level, cam_x, cam_z, height_above_ground,
                    output ready);
endinterface

interface cbwu_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  slot;
    logic [15:0] block_x;
    logic [15:0] block_y;
    logic [2:0]  local_x;
    logic [2:0]  local_y;
    logic        inner;
    logic        out_of_border;
    logic        replaced;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [2:0]  start_level;
    logic        last;

    modport source (output valid, slot, block_x, block_y, local_x, local_y, inner,
                    out_of_border, replaced, start_x, start_y, start_level, last,
                    input ready);
    modport sink   (input valid, slot, block_x, block_y, local_x, local_y, inner,
                    out_of_border, replaced, start_x, start_y, start_level, last,
                    output ready);
endinterface

@@ rtl/core/cbwu_front.sv @@
// Front end: accepts items and works out level, grid, window, border limits and minimum level.
module cbwu_front #(
    parameter int MAX_LEVELS = cbwu_pkg::MAX_LEVELS_DEF
) (
    cbwu_in_if.sink         i_item,
    input  logic [3:0]      i_bs,
    input  logic [3:0]      i_ts,
    input  logic            i_full,
    output logic            o_push,
    output cbwu_pkg::t_job  o_job
);
    import cbwu_pkg::*;

    logic [5:0]      w_araw;
    logic [4:0]      w_active;
    logic [LV_W-1:0] w_lv;
    logic [4:0]      w_shift;
    logic            w_hpos;
    logic [3:0]      w_cnt;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        w_araw = {2'b00, i_ts} - {2'b00, i_bs} + 6'd1;
        if (w_araw[5] || w_araw == 6'd0) begin
            w_active = 5'd1;
        end else if (w_araw > 6'(MAX_LEVELS)) begin
            w_active = 5'(MAX_LEVELS);
        end else begin
            w_active = w_araw[4:0];
        end
        if ({2'b00, i_item.level} >= w_active) begin
            w_lv = LV_W'(w_active - 5'd1);
        end else begin
            w_lv = LV_W'(i_item.level);
        end
        w_shift = {1'b0, i_bs} + 5'(w_lv);

        // bands are half-open: level i while height < 3 * B * 2^i
        w_hpos = !i_item.height_above_ground[15] && (i_item.height_above_ground[14:0] != '0);
        w_cnt  = '0;
        for (int i = 0; i < MAX_LEVELS - 1; i++) begin
            if (w_hpos && (5'(i) < w_active - 5'd1) &&
                ({17'b0, i_item.height_above_ground[14:0]} >=
                 (32'd3 << (6'(i_bs) + 6'(i))))) begin
                w_cnt = w_cnt + 4'd1;
            end
        end

        o_job.action    = i_item.action;
        o_job.lv        = w_lv;
        o_job.gx        = i_item.cam_x >> w_shift;
        o_job.gy        = i_item.cam_z >> w_shift;
        o_job.sx        = {o_job.gx[15:1], 1'b0} - 16'd2;
        o_job.sy        = {o_job.gy[15:1], 1'b0} - 16'd2;
        o_job.px        = o_job.gx[0];
        o_job.py        = o_job.gy[0];
        o_job.lo        = 16'h8000 >> w_shift;
        o_job.hi        = ((17'd1 << i_ts) >> w_shift) + {1'b0, o_job.lo};
        o_job.min_level = (w_cnt > 4'd7) ? 3'd7 : w_cnt[2:0];
    end

endmodule

@@ rtl/core/cbwu_queue.sv @@
// Two-entry queue of classified items between front and back.
module cbwu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cbwu_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output cbwu_pkg::t_job  o_job,
    output logic            o_empty
);
    import cbwu_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ rtl/core/cbwu_back.sv @@
// Back end: slot table memory, match and refill sequencer, result register.
module cbwu_back #(
    parameter int MAX_LEVELS = cbwu_pkg::MAX_LEVELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  cbwu_pkg::t_job  i_head,
    output logic            o_pop,
    cbwu_out_if.source      o_res
);
    import cbwu_pkg::*;

    localparam int DEPTH  = MAX_LEVELS * SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int WORD_W = $bits(t_slot);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS1 = 2'd1;
    localparam logic [1:0] ST_PASS2 = 2'd2;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_slot             s;
        logic              border;
        logic              replaced;
        logic [15:0]       sx;
        logic [15:0]       sy;
        logic [2:0]        min_level;
        logic              last;
    } t_res;

    logic [WORD_W-1:0]  mem [DEPTH];
    logic [WORD_W-1:0]  r_rd;
    logic [1:0]         r_state;
    t_job               r_job;
    logic               r_moved;
    logic               r_lvl_ok;
    logic [SLOT_W-1:0]  r_idx;
    logic [SLOTS-1:0]   r_pc;
    logic [SLOTS-1:0]   r_cc;
    logic [15:0]        r_grid_x [MAX_LEVELS];
    logic [15:0]        r_grid_y [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] r_lvl_vld;
    t_res               r_out;
    logic               r_ovld;

    logic [LVL_W-1:0]   w_hlv;
    logic [LVL_W-1:0]   w_lv;
    logic               w_hmoved;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_slot              w_cur;
    t_slot              w_new;
    logic [15:0]        w_dx;
    logic [15:0]        w_dy;
    logic               w_pc;
    logic [SLOT_W-1:0]  w_ent;
    logic [SLOT_W-1:0]  w_fz;
    logic               w_fz_ok;
    logic               w_take;
    logic               w_adv;
    logic               w_end;

    assign w_hlv    = i_head.lv[LVL_W-1:0];
    assign w_lv     = r_job.lv[LVL_W-1:0];
    assign w_hmoved = (r_grid_x[w_hlv] != i_head.gx) || (r_grid_y[w_hlv] != i_head.gy);
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign w_adv    = !r_ovld || o_res.ready;
    assign w_end    = (r_idx == SLOT_W'(SLOTS - 1));

    // current slot; a level never written reads as zero
    assign w_cur = r_lvl_ok ? t_slot'(r_rd) : '0;

    always_comb begin
        w_dx  = w_cur.bx - r_job.sx;
        w_dy  = w_cur.by - r_job.sy;
        w_pc  = (w_dx < 16'(WIN)) && (w_dy < 16'(WIN)) &&
                (w_cur.inner == inner_at(w_dx[2:0], w_dy[2:0], r_job.px, r_job.py));
        w_ent = SLOT_W'(w_dy[2:0]) * SLOT_W'(WIN) + SLOT_W'(w_dx[2:0]);

        w_fz    = '0;
        w_fz_ok = 1'b0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!r_cc[j]) begin
                w_fz    = SLOT_W'(j);
                w_fz_ok = 1'b1;
            end
        end

        w_take = r_moved && !r_pc[r_idx] && w_fz_ok;
        if (!r_job.action) begin
            w_new = win_entry(r_idx, r_job.sx, r_job.sy, r_job.px, r_job.py);
        end else if (w_take) begin
            w_new = win_entry(w_fz, r_job.sx, r_job.sy, r_job.px, r_job.py);
        end else begin
            w_new = w_cur;
        end
    end

    // read port: slot 0 at item start and at the end of the match pass, otherwise one slot ahead of the one in hand
    always_comb begin
        w_re    = 1'b0;
        w_raddr = ADDR_W'(w_lv) * ADDR_W'(SLOTS) + ADDR_W'(r_idx) + ADDR_W'(1);
        case (r_state)
            ST_IDLE: begin
                w_re    = !i_empty;
                w_raddr = ADDR_W'(w_hlv) * ADDR_W'(SLOTS);
            end
            ST_PASS1: begin
                w_re = 1'b1;
                if (w_end) begin
                    w_raddr = ADDR_W'(w_lv) * ADDR_W'(SLOTS);
                end
            end
            ST_PASS2: begin
                w_re = w_adv && !w_end;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
        w_we    = (r_state == ST_PASS2) && w_adv;
        w_waddr = ADDR_W'(w_lv) * ADDR_W'(SLOTS) + ADDR_W'(r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_new;
        end
        if (w_re) begin
            r_rd <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_out.slot      <= r_idx;
            r_out.s         <= w_new;
            r_out.border    <= ({1'b0, w_new.bx} < {1'b0, r_job.lo}) ||
                               ({1'b0, w_new.by} < {1'b0, r_job.lo}) ||
                               ({1'b0, w_new.bx} >= r_job.hi) ||
                               ({1'b0, w_new.by} >= r_job.hi);
            r_out.replaced  <= !r_job.action || w_take;
            r_out.sx        <= r_job.sx;
            r_out.sy        <= r_job.sy;
            r_out.min_level <= r_job.min_level;
            r_out.last      <= w_end;
        end
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_moved   <= 1'b0;
            r_lvl_ok  <= 1'b0;
            r_idx     <= '0;
            r_pc      <= '0;
            r_cc      <= '0;
            r_lvl_vld <= '0;
            r_ovld    <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_grid_x[i] <= '0;
                r_grid_y[i] <= '0;
            end
        end else begin
            if (r_ovld && o_res.ready) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        // unmoved grid is equal, so the write is harmless
                        r_grid_x[w_hlv] <= i_head.gx;
                        r_grid_y[w_hlv] <= i_head.gy;
                        r_moved  <= i_head.action && w_hmoved;
                        r_lvl_ok <= r_lvl_vld[w_hlv];
                        r_idx    <= '0;
                        r_pc     <= '0;
                        r_cc     <= '0;
                        r_state  <= (i_head.action && w_hmoved) ? ST_PASS1 : ST_PASS2;
                    end
                end
                ST_PASS1: begin
                    r_pc[r_idx] <= w_pc;
                    if (w_pc) begin
                        r_cc[w_ent] <= 1'b1;
                    end
                    if (w_end) begin
                        r_idx   <= '0;
                        r_state <= ST_PASS2;
                    end else begin
                        r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                ST_PASS2: begin
                    if (w_adv) begin
                        r_ovld <= 1'b1;
                        if (w_take) begin
                            r_cc[w_fz] <= 1'b1;
                        end
                        if (w_end) begin
                            r_lvl_vld[w_lv] <= 1'b1;
                            r_state         <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + SLOT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid         = r_ovld;
    assign o_res.slot          = r_out.slot;
    assign o_res.block_x       = r_out.s.bx;
    assign o_res.block_y       = r_out.s.by;
    assign o_res.local_x       = r_out.s.lx;
    assign o_res.local_y       = r_out.s.ly;
    assign o_res.inner         = r_out.s.inner;
    assign o_res.out_of_border = r_out.border;
    assign o_res.replaced      = r_out.replaced;
    assign o_res.start_x       = r_out.sx;
    assign o_res.start_y       = r_out.sy;
    assign o_res.start_level   = r_out.min_level;
    assign o_res.last          = r_out.last;

    a_pass1_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS1) |-> r_moved)
        else $error("match pass entered without a grid move");

    a_write_pass2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_PASS2))
        else $error("slot write outside emit pass");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_idx < SLOT_W'(SLOTS)))
        else $error("slot index out of range");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS2 && w_adv && w_end) |=> (r_state == ST_IDLE && r_ovld))
        else $error("item did not close after last slot");

endmodule

@@ rtl/core/clipmap_block_window_update.sv @@
// Top level of the clipmap block window update.
// Usage:
//  - i_item carries one item (action, level, camera x/z, height above ground);
//    taken on a clock edge with valid and ready high.
//  - o_result gives 36 items per input item, slots 0..35 in order, last on 35.
//  - Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) are for the user to make
//    only while idle; the block itself does not enforce this.
// Sequence:
//  - Init or an update with no grid move: an idle step loads the item and
//    reads slot 0, then the emit pass gives slots 0..35 in order.
//  - Update after a grid move: a match pass over all slots comes before the
//    emit pass. The single read port of the slot memory sets this.
//  - Front accepts into a 2-deep queue while the back end works, so up to two
//    items wait behind the one in progress.
// Reset: clears control, config to block 4 / terrain 12; every level reads as
//  zero until its first item rewrites all of its slots. No clearing pass.
// Stall: the result register holds while o_result.ready is low and the emit
//  pass waits with it; nothing is dropped.
module clipmap_block_window_update #(
    parameter int MAX_LEVELS = cbwu_pkg::MAX_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbwu_in_if.sink     i_item,
    cbwu_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_data
);
    import cbwu_pkg::*;

    logic [3:0] r_bs;     // log2 block edge
    logic [3:0] r_ts;     // log2 terrain edge
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_job       w_in_job;
    t_job       w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= 4'd4;
            r_ts <= 4'd12;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_SIZE:   r_bs <= i_cfg_data;
                REG_TERRAIN_SIZE: r_ts <= i_cfg_data;
                default:          r_bs <= r_bs;
            endcase
        end
    end

    // classify: level clamp, grid cell, window start, border limits, min level
    cbwu_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
        .i_item (i_item),
        .i_bs   (r_bs),
        .i_ts   (r_ts),
        .i_full (w_full),
        .o_push (w_push),
        .o_job  (w_in_job)
    );

    cbwu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_head),
        .o_empty (w_empty)
    );

    // slot table, match and refill, result register
    cbwu_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_result)
    );

endmodule
